>>> sv/rbtp_pkg.sv
package rbtp_pkg;

   localparam int MAX_DIM = 4096;
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int COORD_W = 12;
   localparam int FRAME_W = 32;
   localparam int SAMPLE_W = 16;
   localparam int DEPTH_W = 5;
   localparam int BAYER_W = 3;
   localparam int PATTERN_W = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int BAR_W = 3;
   localparam int NUM_BARS = 8;
   localparam int KW_W = DIM_W + BAR_W;
   localparam int RAMP_W = COORD_W + SAMPLE_W;
   localparam int LAT_A = 4;
   localparam int LAT_B = 4;
   localparam int DEPTH_ENTRIES = 17;
   localparam int DEPTH_IDX_W = $clog2(DEPTH_ENTRIES);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PATTERN = 3'd0,
      REG_WIDTH   = 3'd1,
      REG_HEIGHT  = 3'd2,
      REG_DEPTH   = 3'd3,
      REG_BAYER   = 3'd4
   } reg_index_type;

   typedef enum logic [PATTERN_W-1:0] {
      PAT_RAMP    = 2'd0,
      PAT_BARS    = 2'd1,
      PAT_CHECKER = 2'd2,
      PAT_BOX     = 2'd3
   } pattern_type;

   localparam logic [BAYER_W-1:0] BAYER_RGGB = 3'd0;
   localparam logic [BAYER_W-1:0] BAYER_BGGR = 3'd1;
   localparam logic [BAYER_W-1:0] BAYER_GRBG = 3'd2;
   localparam logic [BAYER_W-1:0] BAYER_GBRG = 3'd3;
   localparam logic [BAYER_W-1:0] BAYER_MONO = 3'd4;

   // Full scale divided by three and two thirds of it, indexed by depth; entry 0 is 16 bits.
   localparam logic [SAMPLE_W-1:0] THIRD_TAB [DEPTH_ENTRIES] = '{
      16'd21845, 16'd0, 16'd1, 16'd2, 16'd5, 16'd10, 16'd21, 16'd42, 16'd85,
      16'd170, 16'd341, 16'd682, 16'd1365, 16'd2730, 16'd5461, 16'd10922, 16'd21845};
   localparam logic [SAMPLE_W-1:0] TWO_THIRD_TAB [DEPTH_ENTRIES] = '{
      16'd43690, 16'd0, 16'd2, 16'd4, 16'd10, 16'd20, 16'd42, 16'd84, 16'd170,
      16'd340, 16'd682, 16'd1364, 16'd2730, 16'd5460, 16'd10922, 16'd21844, 16'd43690};

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic [BAYER_W-1:0] bayer;
      logic [SAMPLE_W-1:0] maxv;
      logic [SAMPLE_W-1:0] third;
      logic [SAMPLE_W-1:0] two_third;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [DIM_W-1:0] ramp_div;
      logic [DIM_W-1:0] block;
      logic [DIM_W-1:0] box;
      logic [DIM_W-1:0] path;
      logic [DIM_W-1:0] span;
      logic [NUM_BARS-2:0][KW_W-1:0] bar_edge;
   } cfg_type;

endpackage

>>> sv/rbtp_div.sv
module rbtp_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 13,
   parameter int STAGES = 4
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);

   localparam int SPS = (NUM_W + STAGES - 1) / STAGES;

   logic [NUM_W-1:0] quo_ff [STAGES];
   logic [NUM_W-1:0] quo_in [STAGES];
   logic [DEN_W-1:0] rem_ff [STAGES];
   logic [DEN_W-1:0] rem_in [STAGES];
   logic [NUM_W-1:0] quo_src [STAGES];
   logic [DEN_W-1:0] rem_src [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign quo_src[s] = num;
         assign rem_src[s] = '0;
      end else begin : g_next
         assign quo_src[s] = quo_ff[s-1];
         assign rem_src[s] = rem_ff[s-1];
      end

      always_comb begin
         logic [NUM_W-1:0] n;
         logic [DEN_W-1:0] r;
         logic [DEN_W:0] t;
         n = quo_src[s];
         r = rem_src[s];
         t = '0;
         for (int k = 0; k < SPS; k++) begin
            if (s * SPS + k < NUM_W) begin
               t = {r, n[NUM_W-1]};
               n = {n[NUM_W-2:0], 1'b0};
               if (t >= {1'b0, den}) begin
                  t = t - {1'b0, den};
                  n[0] = 1'b1;
               end
               r = t[DEN_W-1:0];
            end
         end
         quo_in[s] = n;
         rem_in[s] = r;
      end

      always_ff @(posedge clock) begin
         quo_ff[s] <= quo_in[s];
         rem_ff[s] <= rem_in[s];
      end
   end

   assign quot = quo_ff[STAGES-1];
   assign rem  = rem_ff[STAGES-1];

endmodule

>>> sv/rbtp_delay.sv
module rbtp_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      line_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         line_ff[i] <= line_ff[i-1];
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

>>> sv/rbtp_csr.sv
module rbtp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rbtp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbtp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output rbtp_pkg::cfg_type                   cfg
);
   import rbtp_pkg::*;

   logic [PATTERN_W-1:0] pattern_ff;
   logic [CSR_DATA_W-1:0] width_ff;
   logic [CSR_DATA_W-1:0] height_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [BAYER_W-1:0] bayer_ff;
   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= PAT_RAMP;
         width_ff   <= CSR_DATA_W'(640);
         height_ff  <= CSR_DATA_W'(480);
         depth_ff   <= DEPTH_W'(12);
         bayer_ff   <= BAYER_RGGB;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PATTERN: pattern_ff <= csr_wdata[PATTERN_W-1:0];
            REG_WIDTH:   width_ff   <= csr_wdata;
            REG_HEIGHT:  height_ff  <= csr_wdata;
            REG_DEPTH:   depth_ff   <= csr_wdata[DEPTH_W-1:0];
            REG_BAYER:   bayer_ff   <= csr_wdata[BAYER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic [DIM_W-1:0] mn;
      logic [DIM_W-1:0] bx;
      logic [DEPTH_IDX_W-1:0] idx;
      w = (width_ff > CSR_DATA_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(width_ff);
      h = (height_ff > CSR_DATA_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(height_ff);
      mn = (w < h) ? w : h;
      bx = ((mn >> 3) > DIM_W'(8)) ? (mn >> 3) : DIM_W'(8);
      idx = (depth_ff == '0 || depth_ff > DEPTH_W'(16)) ? '0 : DEPTH_IDX_W'(depth_ff);
      cfg_in.pattern = pattern_ff;
      cfg_in.bayer = bayer_ff;
      cfg_in.maxv = (idx == '0) ? '1 : SAMPLE_W'((17'd1 << idx) - 17'd1);
      cfg_in.third = THIRD_TAB[idx];
      cfg_in.two_third = TWO_THIRD_TAB[idx];
      cfg_in.width = w;
      cfg_in.height = h;
      cfg_in.ramp_div = (w > DIM_W'(1)) ? w - DIM_W'(1) : DIM_W'(1);
      cfg_in.block = ((w >> 4) > DIM_W'(4)) ? (w >> 4) : DIM_W'(4);
      cfg_in.box = bx;
      cfg_in.path = ({1'b0, w} > {1'b0, bx} + 1'b1) ? w - bx : DIM_W'(1);
      cfg_in.span = ({1'b0, h} > {1'b0, bx} + 1'b1) ? h - bx : DIM_W'(1);
      for (int k = 0; k < NUM_BARS - 1; k++) begin
         cfg_in.bar_edge[k] = KW_W'(w) * KW_W'(k + 1);
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/raw_bayer_test_pattern_gen.sv
// Test pattern source: one request per clock while busy is low, each answered by one
// result after acceptance through the input register, set-up stage, four stages of the
// coordinate dividers, four stages of the box row divider and the output register.
// The receiver cannot stall; rsp_valid marks each result for one cycle. busy is
// high during reset and in the cycle after reset while the derived settings settle.
module raw_bayer_test_pattern_gen (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [rbtp_pkg::COORD_W-1:0]        req_col,
   input  logic [rbtp_pkg::COORD_W-1:0]        req_row,
   input  logic [rbtp_pkg::FRAME_W-1:0]        req_frame_number,
   output logic                                rsp_valid,
   output logic [rbtp_pkg::SAMPLE_W-1:0]       rsp_pixel_value,
   output logic                                rsp_outside_frame,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rbtp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rbtp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rbtp_pkg::*;

   localparam int VLAT = 1 + LAT_A + LAT_B + 1;
   localparam int RSP_LAT = VLAT + 1;

   typedef struct packed {
      logic outside;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [SAMPLE_W-1:0] bars;
   } side_a_type;

   typedef struct packed {
      side_a_type a;
      logic [SAMPLE_W-1:0] ramp;
      logic checker_odd;
      logic [DIM_W-1:0] x0;
   } side_b_type;

   cfg_type cfg;
   logic busy_ff;
   logic [VLAT-1:0] valid_ff;
   logic v1_ff;
   logic [COORD_W-1:0] col1_ff;
   logic [COORD_W-1:0] row1_ff;
   logic [FRAME_W-1:0] frame1_ff;
   side_a_type side2_in;
   side_a_type side2_ff;
   logic [RAMP_W-1:0] prod2_ff;
   logic [FRAME_W-1:0] frame2_ff;
   side_a_type side_a_out;
   side_b_type side_b_in;
   side_b_type side_b_out;
   logic [RAMP_W-1:0] ramp_q;
   logic [DIM_W-1:0] ramp_r;
   logic [COORD_W-1:0] cx_q;
   logic [DIM_W-1:0] cx_r;
   logic [COORD_W-1:0] cy_q;
   logic [DIM_W-1:0] cy_r;
   logic [FRAME_W-1:0] fp_q;
   logic [DIM_W-1:0] fp_r;
   logic [FRAME_W-1:0] fs_q;
   logic [DIM_W-1:0] y0;
   logic [SAMPLE_W-1:0] pixel_in;
   logic [SAMPLE_W-1:0] pixel_ff;
   logic outside_ff;

   rbtp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         v1_ff <= 1'b0;
         valid_ff <= '0;
      end else begin
         busy_ff <= 1'b0;
         v1_ff <= start && !busy_ff;
         valid_ff <= {valid_ff[VLAT-2:0], v1_ff};
      end
   end

   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      col1_ff <= req_col;
      row1_ff <= req_row;
      frame1_ff <= req_frame_number;
   end

   always_comb begin
      logic [BAR_W-1:0] bar;
      logic [SAMPLE_W-1:0] r;
      logic [SAMPLE_W-1:0] g;
      logic [SAMPLE_W-1:0] b;
      logic [SAMPLE_W-1:0] mono;
      logic er;
      logic ec;
      bar = '0;
      for (int k = 0; k < NUM_BARS - 1; k++) begin
         if (KW_W'({col1_ff, 3'b000}) >= cfg.bar_edge[k]) begin
            bar = bar + 1'b1;
         end
      end
      r = '0;
      g = '0;
      b = '0;
      mono = '0;
      case (bar)
         3'd0: begin r = cfg.maxv; g = cfg.maxv; b = cfg.maxv; mono = cfg.maxv; end
         3'd1: begin r = cfg.maxv; g = cfg.maxv; mono = cfg.two_third; end
         3'd2: begin g = cfg.maxv; b = cfg.maxv; mono = cfg.two_third; end
         3'd3: begin g = cfg.maxv; mono = cfg.third; end
         3'd4: begin r = cfg.maxv; b = cfg.maxv; mono = cfg.two_third; end
         3'd5: begin r = cfg.maxv; mono = cfg.third; end
         3'd6: begin b = cfg.maxv; mono = cfg.third; end
         default: begin
            r = cfg.maxv >> 2; g = cfg.maxv >> 2; b = cfg.maxv >> 2; mono = cfg.maxv >> 2;
         end
      endcase
      er = !row1_ff[0];
      ec = !col1_ff[0];
      case (cfg.bayer)
         BAYER_RGGB: side2_in.bars = er ? (ec ? r : g) : (ec ? g : b);
         BAYER_BGGR: side2_in.bars = er ? (ec ? b : g) : (ec ? g : r);
         BAYER_GRBG: side2_in.bars = er ? (ec ? g : r) : (ec ? b : g);
         BAYER_GBRG: side2_in.bars = er ? (ec ? g : b) : (ec ? r : g);
         BAYER_MONO: side2_in.bars = mono;
         default:    side2_in.bars = '0;
      endcase
      side2_in.outside = ({1'b0, col1_ff} >= cfg.width) || ({1'b0, row1_ff} >= cfg.height);
      side2_in.col = col1_ff;
      side2_in.row = row1_ff;
   end

   always_ff @(posedge clock) begin
      side2_ff <= side2_in;
      prod2_ff <= RAMP_W'(col1_ff) * RAMP_W'(cfg.maxv);
      frame2_ff <= frame1_ff;
   end

   rbtp_div #(.NUM_W(RAMP_W), .DEN_W(DIM_W), .STAGES(LAT_A)) u_div_ramp (
      .clock (clock), .num (prod2_ff), .den (cfg.ramp_div), .quot (ramp_q), .rem (ramp_r)
   );

   rbtp_div #(.NUM_W(COORD_W), .DEN_W(DIM_W), .STAGES(LAT_A)) u_div_cx (
      .clock (clock), .num (side2_ff.col), .den (cfg.block), .quot (cx_q), .rem (cx_r)
   );

   rbtp_div #(.NUM_W(COORD_W), .DEN_W(DIM_W), .STAGES(LAT_A)) u_div_cy (
      .clock (clock), .num (side2_ff.row), .den (cfg.block), .quot (cy_q), .rem (cy_r)
   );

   rbtp_div #(.NUM_W(FRAME_W), .DEN_W(DIM_W), .STAGES(LAT_A)) u_div_path (
      .clock (clock), .num (frame2_ff), .den (cfg.path), .quot (fp_q), .rem (fp_r)
   );

   rbtp_delay #(.WIDTH($bits(side_a_type)), .DEPTH(LAT_A)) u_delay_a (
      .clock (clock), .din (side2_ff), .dout (side_a_out)
   );

   assign side_b_in.a = side_a_out;
   assign side_b_in.ramp = ramp_q[SAMPLE_W-1:0];
   assign side_b_in.checker_odd = cx_q[0] ^ cy_q[0];
   assign side_b_in.x0 = fp_r;

   rbtp_div #(.NUM_W(FRAME_W), .DEN_W(DIM_W), .STAGES(LAT_B)) u_div_span (
      .clock (clock), .num (fp_q), .den (cfg.span), .quot (fs_q), .rem (y0)
   );

   rbtp_delay #(.WIDTH($bits(side_b_type)), .DEPTH(LAT_B)) u_delay_b (
      .clock (clock), .din (side_b_in), .dout (side_b_out)
   );

   always_comb begin
      logic in_box;
      logic [DIM_W:0] col_w;
      logic [DIM_W:0] row_w;
      col_w = (DIM_W + 1)'(side_b_out.a.col);
      row_w = (DIM_W + 1)'(side_b_out.a.row);
      in_box = (col_w >= {1'b0, side_b_out.x0})
            && (col_w < {1'b0, side_b_out.x0} + {1'b0, cfg.box})
            && (row_w >= {1'b0, y0})
            && (row_w < {1'b0, y0} + {1'b0, cfg.box});
      case (cfg.pattern)
         PAT_RAMP:    pixel_in = side_b_out.ramp;
         PAT_BARS:    pixel_in = side_b_out.a.bars;
         PAT_CHECKER: pixel_in = side_b_out.checker_odd ? (cfg.maxv >> 3) : cfg.maxv;
         default:     pixel_in = in_box ? cfg.maxv : '0;
      endcase
      if (side_b_out.a.outside) begin
         pixel_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      outside_ff <= side_b_out.a.outside;
   end

   assign rsp_valid = valid_ff[VLAT-1];
   assign rsp_pixel_value = pixel_ff;
   assign rsp_outside_frame = outside_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##RSP_LAT rsp_valid)
      else $error("request not answered after the pipeline latency");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside_frame |-> rsp_pixel_value == '0)
      else $error("outside coordinate gave a non-zero sample");

   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_value <= cfg.maxv)
      else $error("sample above full scale");

   a_busy_quiet: assert property (@(posedge clock) disable iff (reset)
      busy |=> !v1_ff)
      else $error("request taken while busy");

endmodule

>>> verif/testbench.sv
module testbench;
   import rbtp_pkg::*;

   typedef struct {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [FRAME_W-1:0] frame;
   } pixel_request_type;

   typedef struct {
      logic [SAMPLE_W-1:0] value;
      logic                outside;
   } pixel_result_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [COORD_W-1:0]     req_col;
   logic [COORD_W-1:0]     req_row;
   logic [FRAME_W-1:0]     req_frame_number;
   logic                   rsp_valid;
   logic [SAMPLE_W-1:0]    rsp_pixel_value;
   logic                   rsp_outside_frame;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   pixel_request_type pending_requests[$];
   pixel_result_type  expected_pixels[$];

   logic [1:0]  sh_pattern;
   logic [12:0] sh_width;
   logic [12:0] sh_height;
   logic [4:0]  sh_depth;
   logic [2:0]  sh_bayer;

   int  mismatches;
   int  requests_taken;
   int  pixels_checked;
   int  csr_writes;
   int  gap_left;
   bit  just_taken;
   bit  gaps_enabled;

   raw_bayer_test_pattern_gen u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_col(req_col), .req_row(req_row), .req_frame_number(req_frame_number),
      .rsp_valid(rsp_valid), .rsp_pixel_value(rsp_pixel_value),
      .rsp_outside_frame(rsp_outside_frame),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int unsigned clamped(input logic [12:0] d);
      return (d > 13'd4096) ? 4096 : int'(d);
   endfunction

   function automatic int unsigned full_scale();
      if (sh_depth == 5'd0 || sh_depth > 5'd16) return 32'hffff;
      return (32'd1 << sh_depth) - 1;
   endfunction

   function automatic void box_place(input logic [FRAME_W-1:0] f, output int unsigned x0,
                                     output int unsigned y0, output int unsigned box);
      int unsigned w, h, m, path, span;
      w = clamped(sh_width);
      h = clamped(sh_height);
      m = (w < h) ? w : h;
      box = (m / 8 > 8) ? m / 8 : 8;
      path = (w > box + 1) ? w - box : 1;
      span = (h > box + 1) ? h - box : 1;
      x0 = f % path;
      y0 = (f / path) % span;
   endfunction

   function automatic pixel_result_type pattern_sample(input pixel_request_type rq);
      pixel_result_type res;
      int unsigned x, y, w, h, maxv, v, bar, r, g, b, blk, x0, y0, box;
      bit er, ec;
      x = rq.col;
      y = rq.row;
      w = clamped(sh_width);
      h = clamped(sh_height);
      maxv = full_scale();
      v = 0;
      res.outside = 1'b0;
      if (x >= w || y >= h) begin
         res.outside = 1'b1;
      end else begin
         case (pattern_type'(sh_pattern))
            PAT_RAMP: v = (x * maxv) / ((w > 1) ? w - 1 : 1);
            PAT_BARS: begin
               bar = (x * 8) / w;
               er = (y % 2) == 0;
               ec = (x % 2) == 0;
               case (bar)
                  0: begin r = maxv; g = maxv; b = maxv; end
                  1: begin r = maxv; g = maxv; b = 0; end
                  2: begin r = 0; g = maxv; b = maxv; end
                  3: begin r = 0; g = maxv; b = 0; end
                  4: begin r = maxv; g = 0; b = maxv; end
                  5: begin r = maxv; g = 0; b = 0; end
                  6: begin r = 0; g = 0; b = maxv; end
                  default: begin r = maxv / 4; g = r; b = r; end
               endcase
               case (sh_bayer)
                  BAYER_RGGB: v = er ? (ec ? r : g) : (ec ? g : b);
                  BAYER_BGGR: v = er ? (ec ? b : g) : (ec ? g : r);
                  BAYER_GRBG: v = er ? (ec ? g : r) : (ec ? b : g);
                  BAYER_GBRG: v = er ? (ec ? g : b) : (ec ? r : g);
                  BAYER_MONO: v = (r + g + b) / 3;
                  default: v = 0;
               endcase
            end
            PAT_CHECKER: begin
               blk = (w / 16 > 4) ? w / 16 : 4;
               v = (((x / blk) + (y / blk)) % 2 == 0) ? maxv : maxv / 8;
            end
            default: begin
               box_place(rq.frame, x0, y0, box);
               v = (x >= x0 && x < x0 + box && y >= y0 && y < y0 + box) ? maxv : 0;
            end
         endcase
      end
      res.value = v[SAMPLE_W-1:0];
      return res;
   endfunction

   // Driver: requests are presented on the falling edge, with random gaps between them when gaps are enabled.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (just_taken) begin
            just_taken = 1'b0;
            if (!gaps_enabled || $urandom_range(0, 9) < 4) gap_left = 0;
            else if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(10, 40);
            else gap_left = $urandom_range(1, 3);
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            start <= 1'b1;
            req_col <= pending_requests[0].col;
            req_row <= pending_requests[0].row;
            req_frame_number <= pending_requests[0].frame;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: takes requests and register writes, and checks each result strobe.
   always @(posedge clock) begin
      pixel_result_type exp_px;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            csr_writes++;
            case (csr_index)
               REG_PATTERN: sh_pattern = csr_wdata[1:0];
               REG_WIDTH:   sh_width = csr_wdata;
               REG_HEIGHT:  sh_height = csr_wdata;
               REG_DEPTH:   sh_depth = csr_wdata[4:0];
               REG_BAYER:   sh_bayer = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result: value %0d outside %0b",
                                              rsp_pixel_value, rsp_outside_frame);
            end else begin
               exp_px = expected_pixels.pop_front();
               pixels_checked++;
               if (rsp_pixel_value !== exp_px.value || rsp_outside_frame !== exp_px.outside)
                  begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected value %0d outside %0b, got %0d %0b",
                              exp_px.value, exp_px.outside, rsp_pixel_value,
                              rsp_outside_frame);
               end
            end
         end
         if (start && !busy) begin
            expected_pixels.push_back(pattern_sample(pending_requests[0]));
            void'(pending_requests.pop_front());
            requests_taken++;
            just_taken = 1'b1;
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || expected_pixels.size() > 0) @(posedge clock);
      repeat (15) @(posedge clock);
   endtask

   task automatic push_request(input int unsigned c, input int unsigned r,
                               input logic [FRAME_W-1:0] f);
      pixel_request_type rq;
      rq.col = c[COORD_W-1:0];
      rq.row = r[COORD_W-1:0];
      rq.frame = f;
      pending_requests.push_back(rq);
   endtask

   function automatic logic [12:0] pick_dim();
      case ($urandom_range(0, 11))
         0: return 13'd1;
         1: return 13'd4096;
         2: return 13'($urandom_range(4097, 8191));
         3: return 13'd0;
         4: return 13'd2;
         5: return 13'($urandom_range(1, 4096));
         default: return 13'($urandom_range(8, 96));
      endcase
   endfunction

   task automatic random_phase(input int n);
      int unsigned w, h, x0, y0, box;
      logic [FRAME_W-1:0] f;
      for (int i = 0; i < n; i++) begin
         w = clamped(sh_width);
         h = clamped(sh_height);
         f = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
         case ($urandom_range(0, 9))
            0, 1: push_request($urandom, $urandom, $urandom);
            2, 3: begin
               box_place(f, x0, y0, box);
               push_request(x0 + $urandom_range(0, box), y0 + $urandom_range(0, box), f);
            end
            default:
               if (w == 0 || h == 0) push_request($urandom, $urandom, f);
               else push_request($urandom_range(0, w - 1), $urandom_range(0, h - 1), f);
         endcase
      end
   endtask

   initial begin
      logic [12:0] dim;
      reset = 1'b1;
      start = 1'b0;
      req_col = '0;
      req_row = '0;
      req_frame_number = '0;
      csr_valid = 1'b0;
      csr_index = REG_PATTERN;
      csr_wdata = '0;
      sh_pattern = PAT_RAMP;
      sh_width = 13'd640;
      sh_height = 13'd480;
      sh_depth = 5'd12;
      sh_bayer = BAYER_RGGB;
      mismatches = 0;
      requests_taken = 0;
      pixels_checked = 0;
      csr_writes = 0;
      gap_left = 0;
      just_taken = 1'b0;
      gaps_enabled = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings first, then each pattern on a small frame at its corners and at inner points.
      push_request(0, 0, 0);
      push_request(639, 479, 32'hffffffff);
      push_request(640, 0, 0);
      push_request(4095, 4095, 32'hffffffff);
      drain();
      for (int p = 0; p < 4; p++) begin
         write_reg(REG_PATTERN, 13'(p));
         write_reg(REG_WIDTH, 13'd64);
         write_reg(REG_HEIGHT, 13'd32);
         write_reg(REG_DEPTH, (p == 1) ? 13'd0 : 13'd16);
         write_reg(REG_BAYER, (p == 1) ? 13'(BAYER_MONO) : 13'(BAYER_GBRG));
         repeat (4) @(posedge clock);
         push_request(0, 0, 0);
         push_request(63, 31, 3);
         push_request(1, 1, 32'hffffffff);
         push_request(56, 30, 100);
         push_request(32, 8, 31);
         drain();
      end

      for (int ph = 0; ph < 24; ph++) begin
         write_reg(REG_PATTERN, 13'($urandom_range(0, 3)));
         dim = pick_dim();
         write_reg(REG_WIDTH, dim);
         dim = pick_dim();
         write_reg(REG_HEIGHT, dim);
         case ($urandom_range(0, 5))
            0: write_reg(REG_DEPTH, 13'd0);
            1: write_reg(REG_DEPTH, 13'd1);
            2: write_reg(REG_DEPTH, 13'd16);
            3: write_reg(REG_DEPTH, 13'($urandom_range(17, 31)));
            default: write_reg(REG_DEPTH, 13'($urandom_range(0, 16)));
         endcase
         write_reg(REG_BAYER, 13'($urandom_range(0, 7)));
         if ($urandom_range(0, 3) == 0)
            write_reg(reg_index_type'(REG_BAYER + 3'($urandom_range(1, 3))), 13'($urandom));
         repeat (4) @(posedge clock);
         gaps_enabled = ($urandom_range(0, 4) != 0);
         random_phase(52);
         drain();
      end

      $display("Covered %0d requests and %0d results across %0d register writes.",
               requests_taken, pixels_checked, csr_writes);
      $display("All four patterns, Bayer orders and depths were swept with frame extremes.");
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
